// ===== src/pcg8_pkg.sv =====
// Shared types, constants and helper functions of the eight-lane PCG32 generator.
package pcg8_pkg;

	localparam logic [63:0] PCG_MUL       = 64'd6364136223846793005;
	localparam logic [63:0] START_DEFAULT = 64'h853c49e6748fea9b;
	localparam logic [63:0] SEQ_DEFAULT   = 64'hda3e39cb94b95bdb;

	localparam int XSH_SHIFT = 18;
	localparam int XSH_DROP  = 27;
	localparam int ROT_POS   = 59;

	localparam int NUM_WORDS = 8;
	localparam int COUNT_W   = 4;

	localparam logic OPC_GENERATE = 1'b0;
	localparam logic OPC_RESEED   = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [COUNT_W-1:0] word_count;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        word_0;
		logic [31:0]        word_1;
		logic [31:0]        word_2;
		logic [31:0]        word_3;
		logic [31:0]        word_4;
		logic [31:0]        word_5;
		logic [31:0]        word_6;
		logic [31:0]        word_7;
		logic [COUNT_W-1:0] words_valid;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_WALK,
		OP_JUMP,
		OP_JINC
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_LOAD,
		ST_SEED_MUL,
		ST_SEED_WAIT,
		ST_JINC_MUL,
		ST_JINC_WAIT,
		ST_GEN_MUL,
		ST_GEN_DONE
	} state_t;

	typedef struct packed {
		logic    seed_load;
		logic    gen_start;
		logic    issue;
		mul_op_t op;
		logic    out_load;
	} dp_cmd_t;

	// Multiplier of a jump by the given number of LCG steps.
	function automatic logic [63:0] pcg_jump_mul(input int steps);
		logic [63:0] m;
		m = 64'd1;
		for (int i = 0; i < steps; i++) begin
			m = m * PCG_MUL;
		end
		return m;
	endfunction

	// Sum of the multiplier powers; times the increment it gives the jump increment.
	function automatic logic [63:0] pcg_jump_sum(input int steps);
		logic [63:0] c;
		c = 64'd0;
		for (int i = 0; i < steps; i++) begin
			c = c * PCG_MUL + 64'd1;
		end
		return c;
	endfunction

	function automatic logic [31:0] xsh_rr(input logic [63:0] s);
		logic [63:0] mixed;
		logic [31:0] x;
		logic [4:0]  r;
		logic [63:0] rot;
		mixed = (s >> XSH_SHIFT) ^ s;
		x     = mixed[XSH_DROP +: 32];
		r     = s[ROT_POS +: 5];
		rot   = {x, x} >> r;
		return rot[31:0];
	endfunction

endpackage

// ===== src/pcg8_mul.sv =====
// Two-stage 64-bit multiply-add, low 64 bits of a*b+c, built from 32-bit partial products.
module pcg8_mul
	import pcg8_pkg::*;
(
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [63:0] c,
	output logic [63:0] y
);

	logic [63:0] ll_n;
	logic [31:0] mid_n;
	logic [63:0] ll_s1;
	logic [31:0] mid_s1;
	logic [63:0] c_s1;

	// Only the low half of the cross products reaches the low 64 bits.
	assign ll_n  = {32'd0, a[31:0]} * {32'd0, b[31:0]};
	assign mid_n = a[31:0] * b[63:32] + a[63:32] * b[31:0];

	always_ff @(posedge clk) begin
		ll_s1  <= ll_n;
		mid_s1 <= mid_n;
		c_s1   <= c;
	end

	assign y = ll_s1 + {mid_s1, 32'd0} + c_s1;

endmodule

// ===== src/pcg8_datapath.sv =====
// Datapath: sequence register, lane states, jump terms, word capture and output register.
module pcg8_datapath
	import pcg8_pkg::*;
#(
	parameter int LANES = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 config_write,
	input  logic [63:0]                          config_data,
	input  in_item_t                             in_data,
	input  dp_cmd_t                              cmd,
	input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] k,
	output out_item_t                            out_data
);

	localparam int LW   = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int HALF = (LANES + 1) / 2;
	localparam int CAP  = (LANES < NUM_WORDS) ? LANES : NUM_WORDS;
	localparam logic [63:0] JUMP_MUL = pcg_jump_mul(LANES);
	localparam logic [63:0] JUMP_SUM = pcg_jump_sum(LANES);

	logic [63:0]        seq_q;
	logic [63:0]        inc_q;
	logic [63:0]        jinc_q;
	logic [63:0]        walk_q;
	logic [63:0]        lane_q [LANES];
	logic [COUNT_W-1:0] count_q;
	logic [31:0]        word_q [NUM_WORDS];
	out_item_t          out_q;

	logic               wb_s1;
	mul_op_t            op_s1;
	logic [LW-1:0]      lane_s1;

	logic [63:0]        seq_eff;
	logic [63:0]        inc_n;
	logic [63:0]        start_n;
	logic [LW-1:0]      lane_rd;
	logic [63:0]        lane_val;
	logic [31:0]        word_n;
	logic [COUNT_W-1:0] count_sat;
	logic [63:0]        mul_a;
	logic [63:0]        mul_b;
	logic [63:0]        mul_c;
	logic [63:0]        mul_y;
	logic [31:0]        word_out [NUM_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (config_write) begin
			seq_q <= config_data;
		end
	end

	// Seeding terms: a zero sequence takes the default, a zero start takes its default.
	always_comb begin
		seq_eff = (seq_q == 64'd0) ? SEQ_DEFAULT : seq_q;
		inc_n   = {seq_eff[62:0], 1'b1};
		start_n = ((START_DEFAULT ^ seq_q) == 64'd0) ? START_DEFAULT : (START_DEFAULT ^ seq_q);
	end

	// Even words of a group come from the first half of the lanes, odd words from the second.
	assign lane_rd  = k[0] ? (LW'(HALF) + (k >> 1)) : (k >> 1);
	assign lane_val = lane_q[lane_rd];
	assign word_n   = xsh_rr(lane_val);

	assign count_sat = (in_data.word_count > COUNT_W'(CAP)) ? COUNT_W'(CAP) : in_data.word_count;

	always_comb begin
		unique case (cmd.op)
			OP_WALK: begin
				mul_a = walk_q;
				mul_b = PCG_MUL;
				mul_c = inc_q;
			end
			OP_JUMP: begin
				mul_a = lane_val;
				mul_b = JUMP_MUL;
				mul_c = jinc_q;
			end
			OP_JINC: begin
				mul_a = inc_q;
				mul_b = JUMP_SUM;
				mul_c = 64'd0;
			end
			default: begin
				mul_a = walk_q;
				mul_b = PCG_MUL;
				mul_c = inc_q;
			end
		endcase
	end

	pcg8_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.c   (mul_c),
		.y   (mul_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_s1 <= 1'b0;
		end else begin
			wb_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= cmd.op;
		lane_s1 <= lane_rd;
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_load) begin
			inc_q  <= inc_n;
			walk_q <= inc_n + start_n;
		end
		if (cmd.gen_start) begin
			count_q <= count_sat;
		end
		if (wb_s1) begin
			unique case (op_s1)
				OP_WALK: begin
					walk_q           <= mul_y;
					lane_q[lane_s1]  <= mul_y;
				end
				OP_JUMP: begin
					lane_q[lane_s1]  <= mul_y;
				end
				OP_JINC: begin
					jinc_q <= mul_y;
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar j = 0; j < NUM_WORDS; j++) begin : g_word
		always_ff @(posedge clk) begin
			if (cmd.issue && cmd.op == OP_JUMP && int'(k) == j) begin
				word_q[j] <= (COUNT_W'(j) < count_q) ? word_n : 32'd0;
			end
		end
		// Words past the lane count never get a lane and stay zero.
		assign word_out[j] = (j < LANES) ? word_q[j] : 32'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.word_0      <= word_out[0];
			out_q.word_1      <= word_out[1];
			out_q.word_2      <= word_out[2];
			out_q.word_3      <= word_out[3];
			out_q.word_4      <= word_out[4];
			out_q.word_5      <= word_out[5];
			out_q.word_6      <= word_out[6];
			out_q.word_7      <= word_out[7];
			out_q.words_valid <= count_q;
		end
	end

	assign out_data = out_q;

endmodule

// ===== src/pcg8_ctrl.sv =====
// Controller: sequences reseed walks and lane jumps, and owns the handshakes.
module pcg8_ctrl
	import pcg8_pkg::*;
#(
	parameter int LANES = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  in_item_t                             in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output dp_cmd_t                              cmd,
	output logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] k
);

	localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

	state_t        state_q;
	state_t        state_n;
	logic [LW-1:0] k_q;
	logic [LW-1:0] k_n;
	logic          out_valid_q;
	logic          accept;
	logic          last;
	logic          out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign last     = (k_q == LW'(LANES - 1));
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_n = state_q;
		k_n     = k_q;
		unique case (state_q)
			ST_IDLE: begin
				k_n = '0;
				if (accept) begin
					if (in_data.opcode == OPC_RESEED) begin
						state_n = ST_SEED_LOAD;
					end else if (in_data.word_count != '0) begin
						state_n = ST_GEN_MUL;
					end
				end
			end
			ST_SEED_LOAD: begin
				k_n     = '0;
				state_n = ST_SEED_MUL;
			end
			ST_SEED_MUL: begin
				state_n = ST_SEED_WAIT;
			end
			ST_SEED_WAIT: begin
				k_n     = last ? '0 : k_q + LW'(1);
				state_n = last ? ST_JINC_MUL : ST_SEED_MUL;
			end
			ST_JINC_MUL: begin
				state_n = ST_JINC_WAIT;
			end
			ST_JINC_WAIT: begin
				state_n = ST_IDLE;
			end
			ST_GEN_MUL: begin
				k_n = last ? '0 : k_q + LW'(1);
				if (last) begin
					state_n = ST_GEN_DONE;
				end
			end
			ST_GEN_DONE: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = OP_WALK;
		in_stall      = (state_q != ST_IDLE);
		cmd.gen_start = accept && (in_data.opcode == OPC_GENERATE) && (in_data.word_count != '0);
		unique case (state_q)
			ST_SEED_LOAD: cmd.seed_load = 1'b1;
			ST_SEED_MUL: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_WALK;
			end
			ST_JINC_MUL: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_JINC;
			end
			ST_GEN_MUL: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_JUMP;
			end
			ST_GEN_DONE: cmd.out_load = out_free;
			default: begin
			end
		endcase
	end

	// Reset starts in the seeding walk so the lanes come up as seeded from sequence zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SEED_LOAD;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			k_q     <= k_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign k         = k_q;

endmodule

// ===== src/pcg32_xsh_rr_eight_lane_generator.sv =====
// Top level of the multi-lane PCG32 XSH-RR generator: controller, datapath and checks.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_stall     in_data (opcode, word_count)
//   out       output     out_valid / out_stall   out_data (word_0..word_7, words_valid)
//   config    input      config_write            config_data (stream_sequence)
//
// A generate item keeps in_stall high while one shared two-stage 64-bit multiply-add jumps
// one lane per cycle, and until the words are loaded into the output register.
// A reseed item keeps in_stall high through the seeding walk, each step of which waits for the last.
// After reset the block runs the same seeding pass with in_stall high.
// The finished group waits in the output register, so the next item is taken while it waits;
// only a group that finds the output register still full holds the block.
module pcg32_xsh_rr_eight_lane_generator
	import pcg8_pkg::*;
#(
	parameter int LANES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        config_write,
	input  logic [63:0] config_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

	dp_cmd_t       cmd;
	logic [LW-1:0] k;

	pcg8_ctrl #(
		.LANES (LANES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.k         (k)
	);

	pcg8_datapath #(
		.LANES (LANES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.config_write (config_write),
		.config_data  (config_data),
		.in_data      (in_data),
		.cmd          (cmd),
		.k            (k),
		.out_data     (out_data)
	);

	// The multiplier is only busy while the input side is held off.
	a_no_issue_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !cmd.issue)
		else $error("multiplier issued while input side open");

	// A finished group never overwrites a result that is still waiting.
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output register loaded while full");

	// An accepted generate item with words to deliver holds the input side next cycle.
	a_gen_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.opcode == OPC_GENERATE && in_data.word_count != '0)
		|=> in_stall)
		else $error("generate item did not start work");

	// Every delivered group carries at least one word.
	a_words_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.words_valid != '0))
		else $error("result with no valid words");

endmodule

// ===== tb/sv/tb_pcg32_xsh_rr_eight_lane_generator.sv =====
// Self-checking testbench of the eight-lane PCG32 XSH-RR generator with an item-level predictor.
`timescale 1ns / 1ps

module tb_pcg32_xsh_rr_eight_lane_generator;
	import pcg8_pkg::*;

	localparam int LANE_COUNT = 8;
	localparam int HALF_LANES = (LANE_COUNT + 1) / 2;
	localparam int SEGMENTS = 7;
	localparam int ITEMS_PER_SEGMENT = 250;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;

	class stream_tracker;
		logic [63:0] lane_state_q[LANE_COUNT];
		logic [63:0] step_inc;
		logic [63:0] jump_mul;
		logic [63:0] jump_inc;
		logic [63:0] seed_seq;
		out_item_t   pending_groups[$];
		int          mismatch_count;
		string       field_names[9] = '{"word_0", "word_1", "word_2", "word_3", "word_4",
			"word_5", "word_6", "word_7", "words_valid"};

		function new();
			seed_seq = 64'd0;
			mismatch_count = 0;
			reseed_lanes();
		endfunction

		// Even words come from the lower half of the lanes, odd words from the upper half.
		function int lane_of(int j);
			return (j % 2) ? HALF_LANES + j / 2 : j / 2;
		endfunction

		function logic [31:0] permuted_word(logic [63:0] s);
			logic [31:0] x;
			logic [4:0]  r;
			x = 32'(((s >> 18) ^ s) >> 27);
			r = s[63:59];
			if (r == 5'd0) begin
				return x;
			end
			return (x >> r) | (x << (32 - r));
		endfunction

		function void reseed_lanes();
			logic [63:0] seq;
			logic [63:0] start;
			logic [63:0] s;
			seq = seed_seq;
			start = START_DEFAULT ^ seq;
			if (start == 64'd0) begin
				start = START_DEFAULT;
			end
			if (seq == 64'd0) begin
				seq = SEQ_DEFAULT;
			end
			step_inc = (seq << 1) | 64'd1;
			s = step_inc + start;
			for (int k = 0; k < LANE_COUNT; k++) begin
				s = s * PCG_MUL + step_inc;
				lane_state_q[lane_of(k) % LANE_COUNT] = s;
			end
			jump_mul = 64'd1;
			jump_inc = 64'd0;
			for (int k = 0; k < LANE_COUNT; k++) begin
				jump_inc = jump_inc * PCG_MUL + step_inc;
				jump_mul = jump_mul * PCG_MUL;
			end
		endfunction

		function void take_request(in_item_t item);
			logic [31:0] w[LANE_COUNT];
			logic [31:0] sel[NUM_WORDS];
			int          n;
			out_item_t   g;
			if (item.opcode == OPC_RESEED) begin
				reseed_lanes();
				return;
			end
			n = int'(item.word_count);
			if (n == 0) begin
				return;
			end
			if (n > NUM_WORDS) begin
				n = NUM_WORDS;
			end
			for (int j = 0; j < LANE_COUNT; j++) begin
				w[j] = permuted_word(lane_state_q[j]);
				lane_state_q[j] = lane_state_q[j] * jump_mul + jump_inc;
			end
			for (int j = 0; j < NUM_WORDS; j++) begin
				sel[j] = (j < n) ? w[lane_of(j) % LANE_COUNT] : 32'd0;
			end
			g.word_0 = sel[0];
			g.word_1 = sel[1];
			g.word_2 = sel[2];
			g.word_3 = sel[3];
			g.word_4 = sel[4];
			g.word_5 = sel[5];
			g.word_6 = sel[6];
			g.word_7 = sel[7];
			g.words_valid = COUNT_W'(n);
			pending_groups.push_back(g);
		endfunction

		function void check_group(out_item_t got);
			out_item_t   want;
			logic [31:0] gw[9];
			logic [31:0] ww[9];
			if (pending_groups.size() == 0) begin
				$display("%0t: unexpected item %h", $time, got);
				mismatch_count++;
				return;
			end
			want = pending_groups.pop_front();
			gw = '{got.word_0, got.word_1, got.word_2, got.word_3, got.word_4, got.word_5,
				got.word_6, got.word_7, 32'(got.words_valid)};
			ww = '{want.word_0, want.word_1, want.word_2, want.word_3, want.word_4, want.word_5,
				want.word_6, want.word_7, 32'(want.words_valid)};
			for (int i = 0; i < 9; i++) begin
				if (gw[i] !== ww[i]) begin
					$display("%0t: %s expected %h, got %h", $time, field_names[i], ww[i], gw[i]);
					mismatch_count++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        config_write;
	logic [63:0] config_data;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;

	stream_tracker tracker;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	pcg32_xsh_rr_eight_lane_generator #(
		.LANES(LANE_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.config_write(config_write),
		.config_data(config_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Result side: check each accepted item, then choose the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				tracker.check_group(out_data);
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic in_item_t make_item(logic op, int count);
		in_item_t item;
		item.opcode = op;
		item.word_count = COUNT_W'(count);
		return item;
	endfunction

	function automatic in_item_t random_item();
		int r;
		r = $urandom_range(99);
		if (r < 6) begin
			return make_item(OPC_RESEED, $urandom_range(15));
		end else if (r < 10) begin
			return make_item(OPC_GENERATE, 0);
		end else if (r < 16) begin
			return make_item(OPC_GENERATE, $urandom_range(15, 9));
		end else if (r < 30) begin
			return make_item(OPC_GENERATE, $urandom_range(7, 1));
		end
		return make_item(OPC_GENERATE, 8);
	endfunction

	task automatic offer_item(input in_item_t item);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_data <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		tracker.take_request(item);
	endtask

	// A reseed or an empty request gives no item, so the block may still be busy after the
	// last group has arrived.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_groups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sequence(input logic [63:0] value);
		config_data <= value;
		config_write <= 1'b1;
		@(posedge clk);
		config_write <= 1'b0;
		tracker.seed_seq = value;
	endtask

	initial begin
		logic [63:0] seg_values[SEGMENTS];
		tracker = new();
		arst_n <= 1'b0;
		config_write <= 1'b0;
		config_data <= 64'd0;
		in_valid <= 1'b0;
		in_data <= make_item(OPC_GENERATE, 8);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part from the reset seeding: full group, short tails, empty and oversized
		// requests, and a reseed whose count is ignored.
		offer_item(make_item(OPC_GENERATE, 8));
		offer_item(make_item(OPC_GENERATE, 1));
		offer_item(make_item(OPC_GENERATE, 7));
		offer_item(make_item(OPC_GENERATE, 0));
		offer_item(make_item(OPC_GENERATE, 15));
		offer_item(make_item(OPC_GENERATE, 9));
		for (int n = 2; n <= 6; n++) begin
			offer_item(make_item(OPC_GENERATE, n));
		end
		offer_item(make_item(OPC_RESEED, 15));
		offer_item(make_item(OPC_GENERATE, 8));
		offer_item(make_item(OPC_RESEED, 0));
		offer_item(make_item(OPC_GENERATE, 3));
		settle();

		// The start-default value makes the start word zero, which falls back to the default.
		seg_values = '{64'hFFFF_FFFF_FFFF_FFFF, START_DEFAULT, 64'd1, {$urandom, $urandom},
			64'h8000_0000_0000_0000, {$urandom, $urandom}, 64'd0};
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 22;
				recv_idle_pct = 64;
			end else if (seg < 4) begin
				send_idle_pct = 64;
				recv_idle_pct = 22;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_sequence(seg_values[seg]);
			offer_item(make_item(OPC_RESEED, $urandom_range(15)));
			for (int i = 0; i < ITEMS_PER_SEGMENT; i++) begin
				if (seg == 4 && i == 100) begin
					hold_request = 1'b1;
				end
				offer_item(random_item());
			end
			settle();
		end

		if (tracker.mismatch_count == 0 && tracker.pending_groups.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
